// ----- hw/rtl/zchp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zchp_pkg: shared types and constants of the zero-cross firing controller
// Event codes, register indexes, reset values and the structs that pass
// between the register file, the event logic and the top level.
// ----------------------------------------------------------------------------
package zchp_pkg;

   localparam int SKIP_COUNT_BITS = 8;
   localparam int VENT_COUNT_BITS = 16;
   localparam int CMP_BITS        = 16;
   localparam int CSR_INDEX_BITS  = 3;
   localparam int CSR_DATA_BITS   = 16;

   // event codes
   localparam logic [1:0] ACT_ZERO_CROSS = 2'd0;
   localparam logic [1:0] ACT_TEMP       = 2'd1;
   localparam logic [1:0] ACT_VENT_TICK  = 2'd2;
   localparam logic [1:0] ACT_VENT_LOAD  = 2'd3;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HEAT_DIVIDER  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PRESSED_OFF   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PRESSED_ON    = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RELEASED_OFF  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RELEASED_ON   = 3'd4;

   // register reset values
   localparam logic signed [15:0] PRESSED_OFF_RESET  = 16'sd1500;
   localparam logic signed [15:0] PRESSED_ON_RESET   = 16'sd1400;
   localparam logic signed [15:0] RELEASED_OFF_RESET = 16'sd1200;
   localparam logic signed [15:0] RELEASED_ON_RESET  = 16'sd1100;

   typedef struct packed {
      logic        [7:0]  heat_divider;
      logic signed [15:0] pressed_off_level;
      logic signed [15:0] pressed_on_level;
      logic signed [15:0] released_off_level;
      logic signed [15:0] released_on_level;
   } cfg_type;

   typedef struct packed {
      logic [1:0]         action;
      logic               crossing_level;
      logic               pump_enable;
      logic               ac_pump_mode;
      logic [7:0]         pump_speed;
      logic signed [15:0] temperature;
      logic               key_pressed;
      logic [15:0]        vent_delay;
   } req_type;

   typedef struct packed {
      logic pump_drive;
      logic heat_fire;
      logic vent_drive;
      logic heat_active;
   } rsp_type;

endpackage

// ----- hw/rtl/zchp_csr.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zchp_csr: configuration registers
// Heat divider and the two thermostat threshold pairs, written by index.
// ----------------------------------------------------------------------------
module zchp_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write,
   input  logic [zchp_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [zchp_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   output zchp_pkg::cfg_type                    cfg
);
   import zchp_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_HEAT_DIVIDER: cfg_in.heat_divider       = csr_wdata[7:0];
            CSR_PRESSED_OFF:  cfg_in.pressed_off_level  = csr_wdata[15:0];
            CSR_PRESSED_ON:   cfg_in.pressed_on_level   = csr_wdata[15:0];
            CSR_RELEASED_OFF: cfg_in.released_off_level = csr_wdata[15:0];
            CSR_RELEASED_ON:  cfg_in.released_on_level  = csr_wdata[15:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.heat_divider       <= '0;
         cfg_ff.pressed_off_level  <= PRESSED_OFF_RESET;
         cfg_ff.pressed_on_level   <= PRESSED_ON_RESET;
         cfg_ff.released_off_level <= RELEASED_OFF_RESET;
         cfg_ff.released_on_level  <= RELEASED_ON_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- hw/rtl/zchp_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zchp_core: event logic and controller state
// Applies one event to the pump, heater, thermostat and vent state per
// step and forms the result from the updated state.
// ----------------------------------------------------------------------------
module zchp_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  zchp_pkg::req_type req,
   input  zchp_pkg::cfg_type cfg,
   output zchp_pkg::rsp_type rsp
);
   import zchp_pkg::*;

   logic [SKIP_COUNT_BITS-1:0] pump_skip_ff, pump_skip_in;
   logic [SKIP_COUNT_BITS-1:0] heat_skip_ff, heat_skip_in;
   logic [VENT_COUNT_BITS-1:0] vent_remaining_ff, vent_remaining_in;
   logic pump_on_ff, pump_on_in;
   logic heating_ff, heating_in;
   logic vent_enabled_ff, vent_enabled_in;
   logic vent_level_ff, vent_level_in;
   logic fire;

   logic [SKIP_COUNT_BITS-1:0] pump_skip_inc;
   logic [SKIP_COUNT_BITS-1:0] heat_skip_inc;
   logic signed [15:0]         off_level;
   logic signed [15:0]         on_level;

   assign pump_skip_inc = pump_skip_ff + 1'b1;
   assign heat_skip_inc = heat_skip_ff + 1'b1;
   assign off_level = req.key_pressed ? cfg.pressed_off_level : cfg.released_off_level;
   assign on_level  = req.key_pressed ? cfg.pressed_on_level  : cfg.released_on_level;

   always_comb begin
      pump_skip_in      = pump_skip_ff;
      pump_on_in        = pump_on_ff;
      heat_skip_in      = heat_skip_ff;
      heating_in        = heating_ff;
      vent_enabled_in   = vent_enabled_ff;
      vent_remaining_in = vent_remaining_ff;
      vent_level_in     = vent_level_ff;
      fire              = 1'b0;
      unique case (req.action)
         ACT_ZERO_CROSS: begin
            if (req.ac_pump_mode && req.crossing_level) begin
               if (!pump_on_ff) begin
                  pump_skip_in = pump_skip_inc;
                  if ((CMP_BITS'(pump_skip_inc) > CMP_BITS'(req.pump_speed))
                      && req.pump_enable) begin
                     pump_on_in = 1'b1;
                  end
               end else begin
                  pump_on_in   = 1'b0;
                  pump_skip_in = '0;
               end
            end
            if (heating_ff) begin
               heat_skip_in = heat_skip_inc;
               if (CMP_BITS'(heat_skip_inc) > CMP_BITS'(cfg.heat_divider)) begin
                  heat_skip_in = '0;
                  fire         = 1'b1;
               end
            end
            if (vent_enabled_ff) begin
               vent_level_in = 1'b1;
            end
         end
         ACT_TEMP: begin
            if (heating_ff) begin
               if (req.temperature > off_level) begin
                  heating_in = 1'b0;
               end
            end else if (req.temperature < on_level) begin
               heating_in = 1'b1;
            end
         end
         ACT_VENT_TICK: begin
            if (vent_remaining_ff != '0) begin
               vent_remaining_in = vent_remaining_ff - 1'b1;
               if (vent_remaining_ff == VENT_COUNT_BITS'(1)) begin
                  vent_level_in   = 1'b0;
                  vent_enabled_in = 1'b0;
               end
            end
         end
         ACT_VENT_LOAD: begin
            vent_remaining_in = VENT_COUNT_BITS'(req.vent_delay);
            if (VENT_COUNT_BITS'(req.vent_delay) == '0) begin
               vent_enabled_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pump_skip_ff      <= '0;
         pump_on_ff        <= 1'b0;
         heat_skip_ff      <= '0;
         heating_ff        <= 1'b0;
         vent_enabled_ff   <= 1'b0;
         vent_remaining_ff <= '0;
         vent_level_ff     <= 1'b0;
      end else if (step) begin
         pump_skip_ff      <= pump_skip_in;
         pump_on_ff        <= pump_on_in;
         heat_skip_ff      <= heat_skip_in;
         heating_ff        <= heating_in;
         vent_enabled_ff   <= vent_enabled_in;
         vent_remaining_ff <= vent_remaining_in;
         vent_level_ff     <= vent_level_in;
      end
   end

   assign rsp.pump_drive  = pump_on_in;
   assign rsp.heat_fire   = fire;
   assign rsp.vent_drive  = vent_level_in;
   assign rsp.heat_active = heating_in;

   // heater pulses only on crossings while heating
   a_fire_needs_heating: assert property (@(posedge clock) disable iff (reset)
      step && fire |-> heating_ff && (req.action == ACT_ZERO_CROSS))
      else $error("heater pulse without heating on a crossing");

   // pump turns on only from an enabled crossing
   a_pump_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(pump_on_ff) |-> $past(step && req.action == ACT_ZERO_CROSS && req.pump_enable))
      else $error("pump turned on outside an enabled crossing");

   // vent drive drops only on a tick
   a_vent_fall: assert property (@(posedge clock) disable iff (reset)
      $fell(vent_level_ff) |-> $past(step && req.action == ACT_VENT_TICK))
      else $error("vent drive dropped outside a tick");

   // vent drive never stands without the vent enabled
   a_vent_level_enabled: assert property (@(posedge clock) disable iff (reset)
      vent_level_ff |-> vent_enabled_ff)
      else $error("vent drive high while vent disabled");

endmodule

// ----- hw/rtl/zero_cross_heat_pump_firing.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zero_cross_heat_pump_firing: zero-cross cycle-skipping heater/pump control
// Takes one event per request (zero-cross, temperature sample, vent tick or
// vent-delay load) and returns one response with the drive levels.
// ----------------------------------------------------------------------------
// The block accepts one request every cycle and returns exactly one response
// per request, in order. A request lands in an input register. Once the
// response register is empty or being taken, the event logic updates the
// controller state and loads the response register, which holds it until
// it is taken. Throughput is one request per cycle as long as responses are
// taken. In steady flow both registers are full, so a cycle with rsp_ready
// low and a request in the input register drops req_ready in that same
// cycle; req_ready follows rsp_ready combinationally. Write the
// configuration registers only while no request is in flight.
// ----------------------------------------------------------------------------
module zero_cross_heat_pump_firing (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_action,
   input  logic                                req_crossing_level,
   input  logic                                req_pump_enable,
   input  logic                                req_ac_pump_mode,
   input  logic [7:0]                          req_pump_speed,
   input  logic signed [15:0]                  req_temperature,
   input  logic                                req_key_pressed,
   input  logic [15:0]                         req_vent_delay,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_pump_drive,
   output logic                                rsp_heat_fire,
   output logic                                rsp_vent_drive,
   output logic                                rsp_heat_active,
   // configuration port
   input  logic                                csr_write,
   input  logic [zchp_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [zchp_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import zchp_pkg::*;

   cfg_type cfg;
   req_type req_ff, req_in;
   rsp_type rsp_ff, rsp_in;
   logic    in_valid_ff, in_valid_in;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    advance;
   logic    step;

   // Advance when the response slot is empty or being taken this cycle.
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign step      = in_valid_ff && advance;
   // Take a new request whenever the input register is empty or empties this cycle.
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      req_in.action         = req_action;
      req_in.crossing_level = req_crossing_level;
      req_in.pump_enable    = req_pump_enable;
      req_in.ac_pump_mode   = req_ac_pump_mode;
      req_in.pump_speed     = req_pump_speed;
      req_in.temperature    = req_temperature;
      req_in.key_pressed    = req_key_pressed;
      req_in.vent_delay     = req_vent_delay;
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = in_valid_ff;
      end
   end

   zchp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   zchp_core u_core (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .req   (req_ff),
      .cfg   (cfg),
      .rsp   (rsp_in)
   );

   // control: valid flags of the two stages
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: capture the request, hold the response until taken
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         req_ff <= req_in;
      end
      if (step) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pump_drive  = rsp_ff.pump_drive;
   assign rsp_heat_fire   = rsp_ff.heat_fire;
   assign rsp_vent_drive  = rsp_ff.vent_drive;
   assign rsp_heat_active = rsp_ff.heat_active;

endmodule
